@@ rtl/pdl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pdl_pkg;

  localparam int POOL_SIZE   = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(POOL_SIZE + 1);
  localparam int ADDR_W      = $clog2(POOL_SIZE);
  localparam int CNT_W       = $clog2(POOL_SIZE + 1);

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Null link is encoded as the pool size.
  localparam idx_t NIL_IDX  = IDX_W'(POOL_SIZE);
  localparam cnt_t POOL_CNT = CNT_W'(POOL_SIZE);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_NODE,
    S_APP_LINK,
    S_WALK,
    S_UNLINK_P,
    S_UNLINK_Q,
    S_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    value_t value;
    idx_t   prev;
    idx_t   next;
  } node_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_value;
    logic  wr_prev;
    logic  wr_next;
    addr_t wr_addr;
    node_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] used_count;
    logic [7:0] free_count;
  } result_t;

  function automatic logic is_node(idx_t i);
    return i < NIL_IDX;
  endfunction

  function automatic addr_t to_addr(idx_t i);
    return i[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pdl_chan_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pdl_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] item_value;

  modport source (output valid, op, item_value, input ready);
  modport sink   (input valid, op, item_value, output ready);
endinterface

interface pdl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] used_count;
  logic [7:0] free_count;

  modport source (output valid, status, used_count, free_count, input ready);
  modport sink   (input valid, status, used_count, free_count, output ready);
endinterface

`default_nettype wire

@@ rtl/pdl_node_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Node store: value, prev and next per node, one write port with per-field
// enables, one registered read port.
module pdl_node_mem (
  input  logic               clk,
  input  pdl_pkg::mem_req_t  mem_req,
  output pdl_pkg::node_t     mem_rd
);
  import pdl_pkg::*;

  value_t value_mem [POOL_SIZE];
  idx_t   prev_mem  [POOL_SIZE];
  idx_t   next_mem  [POOL_SIZE];

  always_ff @(posedge clk) begin
    if (mem_req.wr_value) begin
      value_mem[mem_req.wr_addr] <= mem_req.wr_data.value;
    end
    if (mem_req.wr_prev) begin
      prev_mem[mem_req.wr_addr] <= mem_req.wr_data.prev;
    end
    if (mem_req.wr_next) begin
      next_mem[mem_req.wr_addr] <= mem_req.wr_data.next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      mem_rd.value <= value_mem[mem_req.rd_addr];
      mem_rd.prev  <= prev_mem[mem_req.rd_addr];
      mem_rd.next  <= next_mem[mem_req.rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdl_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// List sequencer: head/tail/free-chain registers and the read-modify-write
// steps on the node store.
module pdl_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  pdl_pkg::value_t    in_value,
  output logic               res_valid,
  input  logic               res_ready,
  output pdl_pkg::result_t   res,
  output pdl_pkg::mem_req_t  mem_req,
  input  pdl_pkg::node_t     mem_rd
);
  import pdl_pkg::*;

  state_t  state_r, state_nxt;
  idx_t    head_r, head_nxt;
  idx_t    tail_r, tail_nxt;
  idx_t    free_head_r, free_head_nxt;
  cnt_t    free_total_r, free_total_nxt;
  cnt_t    fill_r, fill_nxt;     // nodes below this mark have been written
  cnt_t    steps_r, steps_nxt;
  idx_t    cur_r, cur_nxt;
  idx_t    prev_r, prev_nxt;
  idx_t    next_r, next_nxt;
  value_t  key_r, key_nxt;
  status_t status_r, status_nxt;
  logic    fresh_r, fresh_nxt;

  logic accept;
  logic pool_empty;
  logic match;
  logic walk_limit;
  logic walk_on;
  idx_t start_idx;

  assign accept     = in_valid && in_ready;
  assign pool_empty = (free_total_r == '0) || !is_node(free_head_r);
  assign match      = (mem_rd.value == key_r);
  assign walk_limit = (steps_r >= POOL_CNT);
  assign walk_on    = !walk_limit && !match && is_node(mem_rd.next);
  assign start_idx  = (in_op == OP_APPEND) ? free_head_r : head_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_APPEND) begin
            state_nxt = pool_empty ? S_RESULT : S_APP_NODE;
          end else begin
            state_nxt = is_node(head_r) ? S_WALK : S_RESULT;
          end
        end
      end
      S_APP_NODE: state_nxt = is_node(tail_r) ? S_APP_LINK : S_RESULT;
      S_APP_LINK: state_nxt = S_RESULT;
      S_WALK: begin
        if (walk_limit) begin
          state_nxt = S_RESULT;
        end else if (match) begin
          state_nxt = S_UNLINK_P;
        end else if (!is_node(mem_rd.next)) begin
          state_nxt = S_RESULT;
        end
      end
      S_UNLINK_P: state_nxt = S_UNLINK_Q;
      S_UNLINK_Q: state_nxt = S_FREE;
      S_FREE:     state_nxt = S_RESULT;
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // List registers
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    fill_nxt       = fill_r;
    steps_nxt      = steps_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    fresh_nxt      = fresh_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt    = in_value;
          cur_nxt    = start_idx;
          steps_nxt  = '0;
          fresh_nxt  = (free_head_r >= fill_r);
          status_nxt = STAT_DONE;
          if (in_op == OP_APPEND && pool_empty) begin
            status_nxt = STAT_FULL;
          end else if (in_op == OP_REMOVE && !is_node(head_r)) begin
            status_nxt = STAT_NOT_FOUND;
          end
        end
      end
      S_APP_NODE: begin
        // a never-written node links to its successor, as after reset
        if (fresh_r) begin
          free_head_nxt = cur_r + idx_t'(1);
          fill_nxt      = CNT_W'(cur_r) + cnt_t'(1);
        end else begin
          free_head_nxt = mem_rd.next;
        end
        free_total_nxt = free_total_r - cnt_t'(1);
        if (!is_node(tail_r)) begin
          head_nxt = cur_r;
          tail_nxt = cur_r;
        end
      end
      S_APP_LINK: tail_nxt = cur_r;
      S_WALK: begin
        if (walk_limit) begin
          status_nxt = STAT_NOT_FOUND;
        end else if (match) begin
          prev_nxt = mem_rd.prev;
          next_nxt = mem_rd.next;
        end else if (is_node(mem_rd.next)) begin
          cur_nxt   = mem_rd.next;
          steps_nxt = steps_r + cnt_t'(1);
        end else begin
          status_nxt = STAT_NOT_FOUND;
        end
      end
      S_UNLINK_P: begin
        if (!is_node(prev_r)) begin
          head_nxt = next_r;
        end
      end
      S_UNLINK_Q: begin
        if (!is_node(next_r)) begin
          tail_nxt = prev_r;
        end
      end
      S_FREE: begin
        free_head_nxt = cur_r;
        if (free_total_r < POOL_CNT) begin
          free_total_nxt = free_total_r + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // Outputs and memory requests
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    res_valid      = (state_r == S_RESULT);
    res.status     = status_r;
    res.used_count = 8'(POOL_CNT - free_total_r);
    res.free_count = 8'(free_total_r);
    mem_req        = '0;
    unique case (state_r)
      S_IDLE: begin
        mem_req.rd_en   = accept && is_node(start_idx);
        mem_req.rd_addr = to_addr(start_idx);
      end
      S_APP_NODE: begin
        mem_req.wr_value = 1'b1;
        mem_req.wr_prev  = 1'b1;
        mem_req.wr_next  = 1'b1;
        mem_req.wr_addr  = to_addr(cur_r);
        mem_req.wr_data  = '{value: key_r, prev: tail_r, next: NIL_IDX};
      end
      S_APP_LINK: begin
        mem_req.wr_next      = 1'b1;
        mem_req.wr_addr      = to_addr(tail_r);
        mem_req.wr_data.next = cur_r;
      end
      S_WALK: begin
        mem_req.rd_en   = walk_on;
        mem_req.rd_addr = to_addr(mem_rd.next);
      end
      S_UNLINK_P: begin
        mem_req.wr_next      = is_node(prev_r);
        mem_req.wr_addr      = to_addr(prev_r);
        mem_req.wr_data.next = next_r;
      end
      S_UNLINK_Q: begin
        mem_req.wr_prev      = is_node(next_r);
        mem_req.wr_addr      = to_addr(next_r);
        mem_req.wr_data.prev = prev_r;
      end
      S_FREE: begin
        mem_req.wr_value = 1'b1;
        mem_req.wr_prev  = 1'b1;
        mem_req.wr_next  = 1'b1;
        mem_req.wr_addr  = to_addr(cur_r);
        mem_req.wr_data  = '{value: '0, prev: NIL_IDX, next: free_head_r};
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NIL_IDX;
      tail_r       <= NIL_IDX;
      free_head_r  <= '0;
      free_total_r <= POOL_CNT;
      fill_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r  <= steps_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    next_r   <= next_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    fresh_r  <= fresh_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/pooled_doubly_linked_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Append: writes the new node, then links it behind the old tail (no link step
//   on an empty list). Remove: walks the list, one node store read per cycle,
//   then unlinks the match and frees it; an empty-list miss goes straight to result.
// One item in flight; the next is taken once the result has been handed on.
// Reset (rst_n low, synchronous): empty list, free chain 0..POOL_SIZE-1, ready
//   in the first cycle after reset; node store needs no clearing pass.

module pooled_doubly_linked_list (
  input  logic      clk,
  input  logic      rst_n,
  pdl_in_if.sink    in_chan,
  pdl_out_if.source out_chan
);
  import pdl_pkg::*;

  // Engine <-> node store
  mem_req_t mem_req;
  node_t    mem_rd;

  // Engine result handoff
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Output register: holds a finished transaction while the engine takes
  // the next item.
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;
  logic    res_take;

  pdl_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_op     (in_chan.op),
    // sign-extend or truncate to the stored value width
    .in_value  (VALUE_WIDTH'(in_chan.item_value)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rd    (mem_rd)
  );

  pdl_node_mem u_node_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rd  (mem_rd)
  );

  // Output stage free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_chan.ready;
  assign res_take  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_data_r.status;
  assign out_chan.used_count = out_data_r.used_count;
  assign out_chan.free_count = out_data_r.free_count;

endmodule

`default_nettype wire
